/* rtl/ccr_pkg.sv */
// Shared widths, item context and status codes for the circle collision pipeline.
package ccr_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned RAD_W    = 31;
  localparam int unsigned MASS_W   = 32;
  localparam int unsigned CPL_W    = 17;
  localparam int unsigned CPL_BITS = 16;
  localparam logic [CPL_W-1:0] CPL_ONE = CPL_W'(1) << CPL_BITS;

  localparam int unsigned AD_W     = DATA_W + 1;
  localparam int unsigned SQ_W     = 2 * AD_W;
  localparam int unsigned DOT_W    = SQ_W + 1;
  localparam int unsigned SUM_W    = MASS_W + 1;
  localparam int unsigned PC_W     = AD_W + CPL_W;
  localparam int unsigned PC_SPLIT = PC_W / 2;
  localparam int unsigned PP_W     = (PC_W - PC_SPLIT) + AD_W;
  localparam int unsigned MMN_W    = PC_W + AD_W;
  localparam int unsigned MMD_W    = AD_W + CPL_BITS;
  localparam int unsigned MM_W     = 35;
  localparam int unsigned PM_W     = MM_W + MASS_W;
  localparam int unsigned GP_W     = MM_W + CPL_W;
  localparam int unsigned J_W      = MM_W + 1;
  localparam int unsigned JN_W     = J_W + MASS_W;
  localparam int unsigned VN_W     = J_W + AD_W;

  typedef enum logic [1:0] {
    STAT_IMPULSE    = 2'd0,
    STAT_SEPARATE   = 2'd1,
    STAT_DEGENERATE = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] pa_x;
    logic signed [DATA_W-1:0] pa_y;
    logic signed [DATA_W-1:0] pb_x;
    logic signed [DATA_W-1:0] pb_y;
    logic signed [DATA_W-1:0] va_x;
    logic signed [DATA_W-1:0] va_y;
    logic signed [DATA_W-1:0] vb_x;
    logic signed [DATA_W-1:0] vb_y;
    logic [RAD_W-1:0]         r;
    logic [MASS_W-1:0]        ima;
    logic [MASS_W-1:0]        imb;
    logic [CPL_W-1:0]         c;
    logic [SUM_W-1:0]         sum;
    logic [AD_W-1:0]          ad_x;
    logic [AD_W-1:0]          ad_y;
    logic                     dl_x_neg;
    logic                     dl_y_neg;
    logic [AD_W-1:0]          d;
    logic                     pen_neg;
    logic [DOT_W-1:0]         dotm;
    logic                     dot_neg;
    logic                     degen;
    logic                     sep;
    logic [MM_W-1:0]          mm_x;
    logic [MM_W-1:0]          mm_y;
    logic [J_W-1:0]           push_ax;
    logic [J_W-1:0]           push_ay;
    logic [J_W-1:0]           push_bx;
    logic [J_W-1:0]           push_by;
  } ctx_t;

  localparam int unsigned CTX_W = $bits(ctx_t);

endpackage

/* rtl/ccr_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with a carried sideband.
module ccr_sqrt #(
  parameter int unsigned RW = 33,
  parameter int unsigned SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] x_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic [RW-1:0]                vld_q;
  logic [RW-1:0][2*RW-1:0]      x_q;
  logic [RW-1:0][RW+1:0]        rem_q;
  logic [RW-1:0][RW-1:0]        root_q;
  logic [RW-1:0][SW-1:0]        side_q;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int unsigned P = RW - 1 - k;
    logic            vld_in;
    logic [2*RW-1:0] x_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [SW-1:0]   side_in;
    logic [RW+1:0]   cur;
    logic [RW+1:0]   trial;
    logic [RW+1:0]   rem_nx;
    logic [RW-1:0]   root_nx;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign x_in    = x_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign cur   = {rem_in[RW-1:0], x_in[2*P+1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_comb begin
      if (cur >= trial) begin
        rem_nx  = cur - trial;
        root_nx = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nx  = cur;
        root_nx = {root_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_in;
        rem_q[k]  <= rem_nx;
        root_q[k] <= root_nx;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

/* rtl/ccr_div.sv */
// Pipelined restoring divider, several lanes, one quotient bit per stage, with a sideband.
module ccr_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned NW    = 8,
  parameter int unsigned DW    = 8,
  parameter int unsigned QW    = 8,
  parameter int unsigned SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [LANES-1:0][DW-1:0]   den_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SW-1:0]              side_o
);

  logic [QW-1:0]                        vld_q;
  logic [QW-1:0][LANES-1:0][NW-1:0]     rem_q;
  logic [QW-1:0][LANES-1:0][DW-1:0]     den_q;
  logic [QW-1:0][LANES-1:0][QW-1:0]     quo_q;
  logic [QW-1:0][SW-1:0]                side_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned SH = QW - 1 - k;
    logic                     vld_in;
    logic [LANES-1:0][NW-1:0] rem_in;
    logic [LANES-1:0][DW-1:0] den_in;
    logic [LANES-1:0][QW-1:0] quo_in;
    logic [SW-1:0]            side_in;
    logic [LANES-1:0][NW-1:0] rem_nx;
    logic [LANES-1:0][QW-1:0] quo_nx;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rem_nx[l] = rem_in[l];
        quo_nx[l] = quo_in[l];
        if ((rem_in[l] >> SH) >= NW'(den_in[l])) begin
          rem_nx[l]     = rem_in[l] - (NW'(den_in[l]) << SH);
          quo_nx[l][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_nx;
        den_q[k]  <= den_in;
        quo_q[k]  <= quo_nx;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

/* rtl/circle_collision_resolve.sv */
// Top level: pipelined elastic collision response for one pair of circles per beat.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid_i / in_ready_o, 12 ports | pair in
//   out     | out_valid_o / out_ready_i, 9 ports| result out
//
// From accepted beat to result valid, a beat passes through the front end, square root,
// translation setup, first divider, mass split, second divider, impulse setup, third
// divider and output register. One beat enters per cycle when nothing stalls.
// Reset clears all valid bits; payload registers are not reset.
// A stall freezes the whole pipeline only when a result waits and the last divider stage
// also holds one; bubbles keep draining toward the output register otherwise.
module circle_collision_resolve
  import ccr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] pos_a_x_i,
  input  logic signed [DATA_W-1:0] pos_a_y_i,
  input  logic signed [DATA_W-1:0] pos_b_x_i,
  input  logic signed [DATA_W-1:0] pos_b_y_i,
  input  logic signed [DATA_W-1:0] vel_a_x_i,
  input  logic signed [DATA_W-1:0] vel_a_y_i,
  input  logic signed [DATA_W-1:0] vel_b_x_i,
  input  logic signed [DATA_W-1:0] vel_b_y_i,
  input  logic [RAD_W-1:0]         radius_sum_i,
  input  logic [MASS_W-1:0]        inv_mass_a_i,
  input  logic [MASS_W-1:0]        inv_mass_b_i,
  input  logic [CPL_W-1:0]         coupling_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] new_pos_a_x_o,
  output logic signed [DATA_W-1:0] new_pos_a_y_o,
  output logic signed [DATA_W-1:0] new_pos_b_x_o,
  output logic signed [DATA_W-1:0] new_pos_b_y_o,
  output logic signed [DATA_W-1:0] new_vel_a_x_o,
  output logic signed [DATA_W-1:0] new_vel_a_y_o,
  output logic signed [DATA_W-1:0] new_vel_b_x_o,
  output logic signed [DATA_W-1:0] new_vel_b_y_o,
  output logic [1:0]               status_o
);

  function automatic logic [DATA_W-1:0] sat_apply(logic signed [DATA_W-1:0] base,
                                                  logic neg, logic [J_W-1:0] mag);
    logic signed [J_W+1:0] b;
    logic signed [J_W+1:0] m;
    logic signed [J_W+1:0] r;
    b = (J_W+2)'(base);
    m = signed'({2'b00, mag});
    r = neg ? b - m : b + m;
    if (r > (J_W+2)'(32'sh7fffffff)) begin
      return 32'h7fffffff;
    end else if (r < (J_W+2)'(-33'sh080000000)) begin
      return 32'h80000000;
    end else begin
      return r[DATA_W-1:0];
    end
  endfunction

  logic en;

  // front end
  logic                         s1_vld_q;
  ctx_t                         s1_ctx_q, c1;
  logic [1:0][AD_W-1:0]         s1_dvm_q, dvm_d;
  logic [1:0]                   s1_dvn_q, dvn_d;
  logic signed [AD_W-1:0]       dl_x, dl_y, dv_x, dv_y;

  logic                         s2_vld_q;
  ctx_t                         s2_ctx_q;
  logic [1:0][SQ_W-1:0]         s2_sq_q, s2_pd_q, sq_d, pd_d;
  logic [1:0]                   s2_sg_q;

  logic                         s3_vld_q;
  ctx_t                         s3_ctx_q, c3;
  logic [SQ_W-1:0]              s3_x_q;
  logic                         sg0, sg1;

  logic                         sq_vld;
  logic [AD_W-1:0]              sq_root;
  logic [CTX_W-1:0]             sq_side;
  ctx_t                         sq_ctx;

  logic                         s4_vld_q;
  ctx_t                         s4_ctx_q, c4;
  logic [PC_W-1:0]              s4_pc_q;
  logic [AD_W-1:0]              penm;
  logic [AD_W-1:0]              r_ext;

  logic                         s5_vld_q;
  ctx_t                         s5_ctx_q;
  logic [3:0][PP_W-1:0]         s5_pp_q, pp_d;

  logic                         s6_vld_q;
  ctx_t                         s6_ctx_q;
  logic [2:0][MMN_W-1:0]        s6_num_q, num6_d;
  logic [2:0][MMD_W-1:0]        den6;

  logic                         d1_vld;
  logic [2:0][MM_W-1:0]         d1_quo;
  logic [CTX_W-1:0]             d1_side;
  ctx_t                         d1_ctx, c7;

  logic                         s7_vld_q;
  ctx_t                         s7_ctx_q;
  logic [3:0][PM_W-1:0]         s7_pm_q, pm_d;
  logic [GP_W-1:0]              s7_gp_q;

  logic                         s8_vld_q;
  ctx_t                         s8_ctx_q;
  logic [5:0][JN_W-1:0]         s8_num_q, num8_d;
  logic [5:0][SUM_W-1:0]        den8;
  logic [J_W-1:0]               g2;

  logic                         d2_vld;
  logic [5:0][J_W-1:0]          d2_quo;
  logic [CTX_W-1:0]             d2_side;
  ctx_t                         d2_ctx, c9;

  logic                         s9_vld_q;
  ctx_t                         s9_ctx_q;
  logic [3:0][VN_W-1:0]         s9_num_q, num9_d;
  logic [3:0][AD_W-1:0]         den9;

  logic                         d3_vld;
  logic [3:0][J_W-1:0]          d3_quo;
  logic [CTX_W-1:0]             d3_side;
  ctx_t                         d3_ctx;

  logic                         out_valid_q;
  logic [7:0][DATA_W-1:0]       out_q, out_d;
  status_e                      stat_q, stat_d;
  logic                         pneg_x, pneg_y, vneg_x, vneg_y;

  assign en         = out_ready_i || !out_valid_q || !d3_vld;
  assign in_ready_o = en;

  // stage 1: differences, magnitudes, clamp, mass sum
  always_comb begin
    dl_x = AD_W'(pos_a_x_i) - AD_W'(pos_b_x_i);
    dl_y = AD_W'(pos_a_y_i) - AD_W'(pos_b_y_i);
    dv_x = AD_W'(vel_a_x_i) - AD_W'(vel_b_x_i);
    dv_y = AD_W'(vel_a_y_i) - AD_W'(vel_b_y_i);
    c1          = '0;
    c1.pa_x     = pos_a_x_i;
    c1.pa_y     = pos_a_y_i;
    c1.pb_x     = pos_b_x_i;
    c1.pb_y     = pos_b_y_i;
    c1.va_x     = vel_a_x_i;
    c1.va_y     = vel_a_y_i;
    c1.vb_x     = vel_b_x_i;
    c1.vb_y     = vel_b_y_i;
    c1.r        = radius_sum_i;
    c1.ima      = inv_mass_a_i;
    c1.imb      = inv_mass_b_i;
    c1.c        = (coupling_i > CPL_ONE) ? CPL_ONE : coupling_i;
    c1.sum      = SUM_W'(inv_mass_a_i) + SUM_W'(inv_mass_b_i);
    c1.ad_x     = dl_x[AD_W-1] ? AD_W'(-dl_x) : AD_W'(dl_x);
    c1.ad_y     = dl_y[AD_W-1] ? AD_W'(-dl_y) : AD_W'(dl_y);
    c1.dl_x_neg = dl_x[AD_W-1];
    c1.dl_y_neg = dl_y[AD_W-1];
    dvm_d[0]    = dv_x[AD_W-1] ? AD_W'(-dv_x) : AD_W'(dv_x);
    dvm_d[1]    = dv_y[AD_W-1] ? AD_W'(-dv_y) : AD_W'(dv_y);
    dvn_d[0]    = dv_x[AD_W-1];
    dvn_d[1]    = dv_y[AD_W-1];
  end

  // stage 2: squares and dot partial products
  always_comb begin
    sq_d[0] = s1_ctx_q.ad_x * s1_ctx_q.ad_x;
    sq_d[1] = s1_ctx_q.ad_y * s1_ctx_q.ad_y;
    pd_d[0] = s1_dvm_q[0] * s1_ctx_q.ad_x;
    pd_d[1] = s1_dvm_q[1] * s1_ctx_q.ad_y;
  end

  // stage 3: squared length and signed dot product
  always_comb begin
    c3  = s2_ctx_q;
    sg0 = s2_sg_q[0];
    sg1 = s2_sg_q[1];
    if (s2_pd_q[0] == '0) begin
      sg0 = s2_sg_q[1];
    end
    if (s2_pd_q[1] == '0) begin
      sg1 = sg0;
    end
    if (sg0 == sg1) begin
      c3.dotm    = DOT_W'(s2_pd_q[0]) + DOT_W'(s2_pd_q[1]);
      c3.dot_neg = sg0;
    end else if (s2_pd_q[0] < s2_pd_q[1]) begin
      c3.dotm    = DOT_W'(s2_pd_q[1] - s2_pd_q[0]);
      c3.dot_neg = sg1;
    end else begin
      c3.dotm    = DOT_W'(s2_pd_q[0] - s2_pd_q[1]);
      c3.dot_neg = sg0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      s9_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= sq_vld;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= d1_vld;
      s8_vld_q <= s7_vld_q;
      s9_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ctx_q <= c1;
      s1_dvm_q <= dvm_d;
      s1_dvn_q <= dvn_d;
      s2_ctx_q <= s1_ctx_q;
      s2_sq_q  <= sq_d;
      s2_pd_q  <= pd_d;
      s2_sg_q  <= {s1_dvn_q[1] ^ s1_ctx_q.dl_y_neg, s1_dvn_q[0] ^ s1_ctx_q.dl_x_neg};
      s3_ctx_q <= c3;
      s3_x_q   <= s2_sq_q[0] + s2_sq_q[1];
      s4_ctx_q <= c4;
      s4_pc_q  <= penm * sq_ctx.c;
      s5_ctx_q <= s4_ctx_q;
      s5_pp_q  <= pp_d;
      s6_ctx_q <= s5_ctx_q;
      s6_num_q <= num6_d;
      s7_ctx_q <= c7;
      s7_pm_q  <= pm_d;
      s7_gp_q  <= d1_quo[2] * c7.c;
      s8_ctx_q <= s7_ctx_q;
      s8_num_q <= num8_d;
      s9_ctx_q <= c9;
      s9_num_q <= num9_d;
    end
  end

  ccr_sqrt #(
    .RW (AD_W),
    .SW (CTX_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .x_i     (s3_x_q),
    .side_i  (s3_ctx_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign sq_ctx = sq_side;

  // stage 4: penetration, degenerate and separating flags, penetration times coupling
  always_comb begin
    c4         = sq_ctx;
    r_ext      = AD_W'(sq_ctx.r);
    c4.d       = sq_root;
    c4.pen_neg = r_ext < sq_root;
    penm       = c4.pen_neg ? sq_root - r_ext : r_ext - sq_root;
    c4.degen   = (sq_root == '0) || (sq_ctx.sum == '0);
    c4.sep     = (sq_ctx.dotm != '0) && (sq_ctx.dot_neg == c4.pen_neg);
  end

  // stage 5: split wide product into partial products
  always_comb begin
    pp_d[0] = s4_pc_q[PC_SPLIT-1:0] * s4_ctx_q.ad_x;
    pp_d[1] = s4_pc_q[PC_W-1:PC_SPLIT] * s4_ctx_q.ad_x;
    pp_d[2] = s4_pc_q[PC_SPLIT-1:0] * s4_ctx_q.ad_y;
    pp_d[3] = s4_pc_q[PC_W-1:PC_SPLIT] * s4_ctx_q.ad_y;
  end

  // stage 6: join partial products
  always_comb begin
    num6_d[0] = (MMN_W'(s5_pp_q[1]) << PC_SPLIT) + MMN_W'(s5_pp_q[0]);
    num6_d[1] = (MMN_W'(s5_pp_q[3]) << PC_SPLIT) + MMN_W'(s5_pp_q[2]);
    num6_d[2] = MMN_W'(s5_ctx_q.dotm);
    den6[0]   = {s6_ctx_q.d, CPL_BITS'(0)};
    den6[1]   = {s6_ctx_q.d, CPL_BITS'(0)};
    den6[2]   = MMD_W'(s6_ctx_q.d);
  end

  ccr_div #(
    .LANES (3),
    .NW    (MMN_W),
    .DW    (MMD_W),
    .QW    (MM_W),
    .SW    (CTX_W)
  ) u_div_mtd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s6_vld_q),
    .num_i   (s6_num_q),
    .den_i   (den6),
    .side_i  (s6_ctx_q),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .side_o  (d1_side)
  );

  assign d1_ctx = d1_side;

  // stage 7: translation vector, mass products, coupled approach speed
  always_comb begin
    c7       = d1_ctx;
    c7.mm_x  = d1_quo[0];
    c7.mm_y  = d1_quo[1];
    c7.degen = d1_ctx.degen || ((d1_quo[0] == '0) && (d1_quo[1] == '0));
    pm_d[0]  = d1_quo[0] * d1_ctx.ima;
    pm_d[1]  = d1_quo[0] * d1_ctx.imb;
    pm_d[2]  = d1_quo[1] * d1_ctx.ima;
    pm_d[3]  = d1_quo[1] * d1_ctx.imb;
  end

  // stage 8: push and impulse numerators
  always_comb begin
    g2 = {s7_gp_q[GP_W-2:CPL_BITS], 1'b0};
    for (int l = 0; l < 4; l++) begin
      num8_d[l] = JN_W'(s7_pm_q[l]);
    end
    num8_d[4] = g2 * s7_ctx_q.ima;
    num8_d[5] = g2 * s7_ctx_q.imb;
    for (int l = 0; l < 6; l++) begin
      den8[l] = s8_ctx_q.sum;
    end
  end

  ccr_div #(
    .LANES (6),
    .NW    (JN_W),
    .DW    (SUM_W),
    .QW    (J_W),
    .SW    (CTX_W)
  ) u_div_mass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_vld_q),
    .num_i   (s8_num_q),
    .den_i   (den8),
    .side_i  (s8_ctx_q),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .side_o  (d2_side)
  );

  assign d2_ctx = d2_side;

  // stage 9: pushes into context, velocity change numerators
  always_comb begin
    c9         = d2_ctx;
    c9.push_ax = d2_quo[0];
    c9.push_bx = d2_quo[1];
    c9.push_ay = d2_quo[2];
    c9.push_by = d2_quo[3];
    num9_d[0]  = d2_quo[4] * d2_ctx.ad_x;
    num9_d[1]  = d2_quo[4] * d2_ctx.ad_y;
    num9_d[2]  = d2_quo[5] * d2_ctx.ad_x;
    num9_d[3]  = d2_quo[5] * d2_ctx.ad_y;
    for (int l = 0; l < 4; l++) begin
      den9[l] = s9_ctx_q.d;
    end
  end

  ccr_div #(
    .LANES (4),
    .NW    (VN_W),
    .DW    (AD_W),
    .QW    (J_W),
    .SW    (CTX_W)
  ) u_div_vel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s9_vld_q),
    .num_i   (s9_num_q),
    .den_i   (den9),
    .side_i  (s9_ctx_q),
    .valid_o (d3_vld),
    .quo_o   (d3_quo),
    .side_o  (d3_side)
  );

  assign d3_ctx = d3_side;

  // final: apply pushes unless degenerate, and impulse unless degenerate or separating, with saturation
  always_comb begin
    pneg_x   = d3_ctx.pen_neg ^ d3_ctx.dl_x_neg;
    pneg_y   = d3_ctx.pen_neg ^ d3_ctx.dl_y_neg;
    vneg_x   = ~(d3_ctx.dot_neg ^ d3_ctx.dl_x_neg);
    vneg_y   = ~(d3_ctx.dot_neg ^ d3_ctx.dl_y_neg);
    out_d[0] = d3_ctx.pa_x;
    out_d[1] = d3_ctx.pa_y;
    out_d[2] = d3_ctx.pb_x;
    out_d[3] = d3_ctx.pb_y;
    out_d[4] = d3_ctx.va_x;
    out_d[5] = d3_ctx.va_y;
    out_d[6] = d3_ctx.vb_x;
    out_d[7] = d3_ctx.vb_y;
    stat_d   = STAT_DEGENERATE;
    if (!d3_ctx.degen) begin
      out_d[0] = sat_apply(d3_ctx.pa_x, pneg_x, d3_ctx.push_ax);
      out_d[1] = sat_apply(d3_ctx.pa_y, pneg_y, d3_ctx.push_ay);
      out_d[2] = sat_apply(d3_ctx.pb_x, !pneg_x, d3_ctx.push_bx);
      out_d[3] = sat_apply(d3_ctx.pb_y, !pneg_y, d3_ctx.push_by);
      stat_d   = STAT_SEPARATE;
      if (!d3_ctx.sep) begin
        out_d[4] = sat_apply(d3_ctx.va_x, vneg_x, d3_quo[0]);
        out_d[5] = sat_apply(d3_ctx.va_y, vneg_y, d3_quo[1]);
        out_d[6] = sat_apply(d3_ctx.vb_x, !vneg_x, d3_quo[2]);
        out_d[7] = sat_apply(d3_ctx.vb_y, !vneg_y, d3_quo[3]);
        stat_d   = STAT_IMPULSE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!out_valid_q || out_ready_i) && d3_vld) begin
      out_q  <= out_d;
      stat_q <= stat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_pos_a_x_o = out_q[0];
  assign new_pos_a_y_o = out_q[1];
  assign new_pos_b_x_o = out_q[2];
  assign new_pos_b_y_o = out_q[3];
  assign new_vel_a_x_o = out_q[4];
  assign new_vel_a_y_o = out_q[5];
  assign new_vel_b_x_o = out_q[6];
  assign new_vel_b_y_o = out_q[7];
  assign status_o      = stat_q;

`ifndef ASSERT_OFF
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input blocked without a stalled result");

  a_root_bounds_axes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld |-> (sq_ctx.ad_x <= sq_root) && (sq_ctx.ad_y <= sq_root))
    else $error("root below an axis distance");

  a_push_within_mtd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d2_vld && !d2_ctx.degen) |->
      (d2_quo[0] <= J_W'(d2_ctx.mm_x)) && (d2_quo[2] <= J_W'(d2_ctx.mm_y)))
    else $error("push exceeds translation");
`endif

endmodule
